// File: sv/inverted_page_table_translator_defines.svh
// ----------------------------------------------------------------------------
// inverted page table translator assertion macros
// shared concurrent assertion forms, all reset-gated
// ----------------------------------------------------------------------------
`ifndef INVERTED_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define INVERTED_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// same-cycle implication
`define IPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg
// shared constants, codes and types of the inverted page table translator
// ----------------------------------------------------------------------------
package ipt_pkg;

  // fixed field widths
  localparam int SLOT_BITS     = 8;
  localparam int PAGE_BITS     = 10;
  localparam int OFFSET_BITS   = 12;
  localparam int VADDR_BITS    = PAGE_BITS + OFFSET_BITS;
  localparam int PADDR_BITS    = SLOT_BITS + OFFSET_BITS;
  localparam int PCT_BITS      = 7;
  localparam int ENTRY_BITS    = PAGE_BITS + 1;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 64;

  // parameter defaults
  localparam int DEF_FRAME_COUNT = 256;
  localparam int DEF_COUNT_BITS  = 32;

  // percent arithmetic
  localparam logic [PCT_BITS-1:0] PCT_MAX = PCT_BITS'(100);
  localparam int PCT_STEPS = PCT_BITS;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // divider status back to the sequencer
  typedef struct packed {
    logic                done;
    logic [PCT_BITS-1:0] pct;
  } pct_res_t;

endpackage

// File: sv/ipt_pct_div.sv
// ----------------------------------------------------------------------------
// ipt_pct_div
// restoring divider for floor(fault * 100 / total), one quotient bit a cycle
// ----------------------------------------------------------------------------
module ipt_pct_div #(
  parameter int COUNT_BITS = ipt_pkg::DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] fault_count,
  input  logic [COUNT_BITS-1:0] total_count,
  output ipt_pkg::pct_res_t     res
);

  localparam int NW = COUNT_BITS + ipt_pkg::PCT_BITS;
  localparam int CW = $clog2(ipt_pkg::PCT_STEPS);

  logic [NW-1:0]                rem;
  logic [NW-1:0]                dsh;
  logic [ipt_pkg::PCT_BITS-1:0] quo;
  logic [CW-1:0]                cnt;
  logic                         busy;
  logic                         done;
  logic                         fits;
  logic [NW-1:0]                fault_ext;

  assign fault_ext = NW'(fault_count);
  assign fits      = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      // fault * 100 as 64 + 32 + 4
      rem <= (fault_ext << 6) + (fault_ext << 5) + (fault_ext << 2);
      dsh <= NW'(total_count) << (ipt_pkg::PCT_STEPS - 1);
      quo <= '0;
      cnt <= CW'(ipt_pkg::PCT_STEPS - 1);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[ipt_pkg::PCT_BITS-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt - CW'(1);
    end
  end

  assign res = {done, quo};

endmodule

// File: sv/inverted_page_table_translator.sv
// ----------------------------------------------------------------------------
// inverted_page_table_translator
// inverted page table mmu: frame table loads, page lookups, fault statistics
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     word contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser operation, tdata slot/page/vaddr
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser hit, tdata frame..hit percent
//
// - after reset a clearing pass walks the frame table with s_axis_tready low
// - a load: accept, then the result word goes to the output register
// - a translate is a linear scan of the frame table through its single read
//   port (one entry a cycle, stops at the first match), then the percent divider
// - one word is in flight at a time; a new word is accepted while the
//   previous result still sits in the output register
// - a stalled m_axis only holds the block when the next result is ready
//
`include "inverted_page_table_translator_defines.svh"

module inverted_page_table_translator #(
  parameter int FRAME_COUNT = ipt_pkg::DEF_FRAME_COUNT,
  parameter int COUNT_BITS  = ipt_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] frame_slot, [17:8] page_value, [39:18] virtual_address
  input  logic [ipt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] frame_number, [17:8] virtual_page, [29:18] page_offset,
  // [49:30] physical_address, [56:50] miss_percent, [63:57] hit_percent
  output logic [ipt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  // [0] hit
  output logic                              m_axis_tuser
);

  localparam int FW        = $clog2(FRAME_COUNT);
  localparam int MEM_DEPTH = 1 << FW;
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAME_COUNT - 1);

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_COUNT  = 3'd3;
  localparam logic [2:0] ST_START  = 3'd4;
  localparam logic [2:0] ST_WAIT   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // input word fields
  logic                             in_op;
  logic [ipt_pkg::SLOT_BITS-1:0]    in_slot;
  logic [ipt_pkg::PAGE_BITS-1:0]    in_page;
  logic [ipt_pkg::VADDR_BITS-1:0]   in_vaddr;

  assign in_op    = s_axis_tuser;
  assign in_slot  = s_axis_tdata[7:0];
  assign in_page  = s_axis_tdata[17:8];
  assign in_vaddr = s_axis_tdata[39:18];

  logic [2:0]  state;
  logic        accept;
  logic        out_free;

  // frame table: {valid, page} per frame
  logic [ipt_pkg::ENTRY_BITS-1:0] mem [MEM_DEPTH];
  logic [ipt_pkg::ENTRY_BITS-1:0] rd_data;
  logic [ipt_pkg::ENTRY_BITS-1:0] wr_data;
  logic [FW-1:0]                  wr_addr;
  logic                           wr_en;

  logic [FW-1:0] clr_idx;
  logic [FW-1:0] iss_idx;   // address read this cycle
  logic [FW-1:0] chk_idx;   // address whose data is in rd_data
  logic          pend;
  logic          match;

  // item under work
  logic                             hit_r;
  logic [ipt_pkg::SLOT_BITS-1:0]    frame_r;
  logic [ipt_pkg::PAGE_BITS-1:0]    vpage_r;
  logic [ipt_pkg::OFFSET_BITS-1:0]  off_r;

  // statistics
  logic [COUNT_BITS-1:0]            trans_cnt;
  logic [COUNT_BITS-1:0]            fault_cnt;
  logic [ipt_pkg::PCT_BITS-1:0]     miss_pct;
  logic [ipt_pkg::PCT_BITS-1:0]     hit_pct;
  logic [ipt_pkg::PCT_BITS-1:0]     miss_clamped;

  ipt_pkg::pct_res_t div_res;
  logic              div_start;

  logic slot_ok;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign slot_ok       = (32'(in_slot) < FRAME_COUNT);
  assign match         = pend && rd_data[ipt_pkg::PAGE_BITS]
                         && (rd_data[ipt_pkg::PAGE_BITS-1:0] == vpage_r);
  assign div_start     = (state == ST_START);
  assign miss_clamped  = (div_res.pct > ipt_pkg::PCT_MAX) ? ipt_pkg::PCT_MAX : div_res.pct;

  // single write port: clearing pass or load
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (accept && in_op == ipt_pkg::OP_LOAD && slot_ok) begin
      wr_en   = 1'b1;
      wr_addr = FW'(in_slot);
      wr_data = {1'b1, in_page};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[iss_idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      trans_cnt <= '0;
      fault_cnt <= '0;
      miss_pct  <= '0;
      hit_pct   <= '0;
      pend      <= 1'b0;
      iss_idx   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + FW'(1);
          if (clr_idx == LAST_FRAME) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          iss_idx <= '0;
          pend    <= 1'b0;
          if (accept) begin
            state <= (in_op == ipt_pkg::OP_XLATE) ? ST_SEARCH : ST_OUT;
          end
        end
        ST_SEARCH: begin
          pend    <= 1'b1;
          iss_idx <= iss_idx + FW'(1);
          if (match || (pend && chk_idx == LAST_FRAME)) begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          // saturating counts
          if (trans_cnt != '1) begin
            trans_cnt <= trans_cnt + COUNT_BITS'(1);
          end
          if (!hit_r && fault_cnt != '1) begin
            fault_cnt <= fault_cnt + COUNT_BITS'(1);
          end
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_res.done) begin
            miss_pct <= miss_clamped;
            hit_pct  <= ipt_pkg::PCT_MAX - miss_clamped;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item registers, no reset needed
  always_ff @(posedge clk) begin
    chk_idx <= iss_idx;
    if (accept) begin
      hit_r   <= 1'b0;
      frame_r <= '0;
      if (in_op == ipt_pkg::OP_XLATE) begin
        vpage_r <= in_vaddr[ipt_pkg::VADDR_BITS-1:ipt_pkg::OFFSET_BITS];
        off_r   <= in_vaddr[ipt_pkg::OFFSET_BITS-1:0];
      end else begin
        vpage_r <= '0;
        off_r   <= '0;
      end
    end else if (state == ST_SEARCH && match) begin
      hit_r   <= 1'b1;
      frame_r <= ipt_pkg::SLOT_BITS'(chk_idx);
    end
  end

  ipt_pct_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .fault_count (fault_cnt),
    .total_count (trans_cnt),
    .res         (div_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  logic [ipt_pkg::PADDR_BITS-1:0] paddr;
  assign paddr = hit_r ? {frame_r, off_r} : '0;

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_axis_tuser <= hit_r;
      m_axis_tdata <= {hit_pct, miss_pct, paddr, off_r, vpage_r, frame_r};
    end
  end

  // checks
  `IPT_ASSERT_NOW(a_fault_le_trans, clk, rst, 1'b1, fault_cnt <= trans_cnt,
    "fault count exceeds translation count")
  `IPT_ASSERT_NOW(a_pct_sum, clk, rst, state == ST_IDLE && trans_cnt != '0,
    miss_pct + hit_pct == ipt_pkg::PCT_MAX, "percentages do not add up to 100")
  `IPT_ASSERT_NEXT(a_xlate_search, clk, rst, accept && in_op == ipt_pkg::OP_XLATE,
    state == ST_SEARCH, "translate word did not start a search")
  `IPT_ASSERT_NEXT(a_scan_ends, clk, rst,
    state == ST_SEARCH && pend && chk_idx == LAST_FRAME, state == ST_COUNT,
    "search ran past the last frame")
  `IPT_ASSERT_NEXT(a_load_out, clk, rst, accept && in_op == ipt_pkg::OP_LOAD,
    state == ST_OUT, "load word did not go straight to output")

endmodule
